// File: rtl/core/tivc_pkg.sv
// Shared widths, register indexes, interface structs and helpers of the trajectory visit counter.
package tivc_pkg;

    localparam int COORD_BITS = 32;
    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 32;
    localparam int CFG_BITS   = 32;
    localparam int IDX_BITS   = 3;

    // Differences of two coordinates and of two timestamps.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int DT_W   = TIME_BITS + 1;

    // Operands of the scaling unit: outside length, time magnitude, segment length.
    localparam int OUT_W  = COORD_BITS + 1;
    localparam int MAG_W  = TIME_BITS;
    localparam int DIST_W = COORD_BITS;
    localparam int PROD_W = OUT_W + MAG_W;

    // The quotient saturates at 2^QBITS.
    localparam int QBITS  = 40;
    localparam int Q_W    = QBITS + 1;
    localparam int HEAD_W = PROD_W - QBITS;
    localparam int INS_W  = QBITS + 2;
    localparam int STEP_W = $clog2(QBITS > MAG_W ? QBITS : MAG_W);

    localparam logic [IDX_BITS-1:0] REG_LOWER = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_UPPER = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_MIN   = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_MAX   = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] REG_MODE  = IDX_BITS'(4);

    typedef struct packed {
        logic [COORD_BITS-1:0] lower_bound;
        logic [COORD_BITS-1:0] upper_bound;
        logic [CFG_BITS-1:0]   min_duration;
        logic [CFG_BITS-1:0]   max_duration;
        logic                  duration_mode;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [OUT_W-1:0]  out_val;
        logic [MAG_W-1:0]  mag;
        logic [DIST_W-1:0] divisor;
    } md_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quot;
    } md_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LAUNCH,
        ST_WAIT,
        ST_CHECK,
        ST_FIN
    } tivc_state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_SAT,
        MD_DIV,
        MD_DONE
    } md_state_t;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                      input logic [1:0] inc);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS + 1)'(inc);
        sat_add = s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/trajectory_interval_visit_counter.sv
// Top level of the trajectory interval visit counter: sequencer, segment tests and output word.
//
// Nodes arrive on the input channel (position, timestamp, path_start, end_of_data) under
// in_valid / in_stall; each node after the first of a path forms a segment with the node
// before it, and the visits of that segment go into a saturating counter. A node with
// end_of_data set delivers the total as one word on the output channel (out_valid /
// out_stall) and clears the counter and the stored node.
// The configuration registers are written through cfg_write_en, cfg_index and cfg_data;
// the user must write them only while no node is in flight; the block does not enforce this.
// One node is handled at a time. In plain mode a node passes through the evaluate and
// finish states before the next can be accepted. In duration mode the shared bit-serial
// scaling unit runs once per tested case, at most twice per node: 32 multiply steps and
// 40 divide steps per case, with no divide steps when the quotient saturates. The total
// word is loaded into its register in the finish state of the end node.
// The output word sits in its own register, so a new node is accepted while it waits;
// an end node that finds that register still full holds until the receiver takes it.
// Reset clears the configuration, the counter and the stored node; no clearing pass.
module trajectory_interval_visit_counter
    import tivc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [IDX_BITS-1:0]          cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] position,
    input  logic signed [TIME_BITS-1:0]  timestamp,
    input  logic                         path_start,
    input  logic                         end_of_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COUNT_BITS-1:0]        visit_total
);

    cfg_t     cfg;
    md_req_t  md_req;
    md_stat_t md_stat;

    tivc_state_t state_reg, state_next;

    logic [COORD_BITS-1:0] prev_pos_reg;
    logic [TIME_BITS-1:0]  prev_time_reg;
    logic                  have_prev_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] visit_total_reg;

    logic [COORD_BITS-1:0] a_reg, b_reg;
    logic [DT_W-1:0]       dt_reg;
    logic                  seg_reg, last_reg;
    logic                  case2_reg, case_sel_reg, b_above_reg;
    logic [DIFF_W-1:0]     d_llo_reg, d_hiu_reg, d_bu_reg, d_lb_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [INS_W-1:0]      inside_reg;

    logic accept, eval_en, grab, fin_load, out_free;

    logic signed [DIFF_W-1:0] a_x, b_x, l_x, u_x, lo_x, hi_x;
    logic signed [DIFF_W-1:0] d_llo, d_hiu, d_bu, d_lb, dist_x;
    logic signed [DT_W-1:0]   dt_new, dt_s, dt_abs;
    logic                     p_span, p_inner, case1, case2;
    logic [DIFF_W:0]          out1_sum;
    logic [OUT_W-1:0]         out_sel;
    logic signed [INS_W-1:0]  dt_ext, q_ext, inside_new, min_ext, max_ext;
    logic                     in_range;

    tivc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    tivc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .stat  (md_stat)
    );

    // Segment geometry against the interval.
    always_comb
    begin
        a_x  = {a_reg[COORD_BITS-1], a_reg};
        b_x  = {b_reg[COORD_BITS-1], b_reg};
        l_x  = {cfg.lower_bound[COORD_BITS-1], cfg.lower_bound};
        u_x  = {cfg.upper_bound[COORD_BITS-1], cfg.upper_bound};
        lo_x = (a_x < b_x) ? a_x : b_x;
        hi_x = (a_x < b_x) ? b_x : a_x;

        p_span  = (lo_x <= l_x) && (hi_x >= l_x);
        p_inner = (lo_x > l_x) && (lo_x <= u_x);
        case1   = ((a_x <= l_x) && (b_x > u_x)) || ((a_x >= u_x) && (b_x < l_x));
        case2   = (a_x > l_x) && (a_x <= u_x) && ((b_x > u_x) || (b_x < l_x));

        d_llo  = l_x - lo_x;
        d_hiu  = hi_x - u_x;
        d_bu   = b_x - u_x;
        d_lb   = l_x - b_x;
        dist_x = hi_x - lo_x;

        dt_new = $signed({timestamp[TIME_BITS-1], timestamp})
               - $signed({prev_time_reg[TIME_BITS-1], prev_time_reg});
        dt_s   = dt_reg;
        dt_abs = dt_s[DT_W-1] ? -dt_s : dt_s;
    end

    // Operand of the case being scaled, and the time inside from the unit's quotient.
    always_comb
    begin
        out1_sum = {d_llo_reg[DIFF_W-1], d_llo_reg}
                 + (d_hiu_reg[DIFF_W-1] ? {(DIFF_W + 1){1'b0}}
                                        : {d_hiu_reg[DIFF_W-1], d_hiu_reg});
        out_sel  = case_sel_reg ? (b_above_reg ? d_bu_reg : d_lb_reg) : out1_sum[OUT_W-1:0];

        dt_ext     = {{(INS_W - DT_W){dt_reg[DT_W-1]}}, dt_reg};
        q_ext      = {{(INS_W - Q_W){1'b0}}, md_stat.quot};
        inside_new = dt_reg[DT_W-1] ? (dt_ext + q_ext) : (dt_ext - q_ext);

        min_ext  = {{(INS_W - CFG_BITS){cfg.min_duration[CFG_BITS-1]}}, cfg.min_duration};
        max_ext  = {{(INS_W - CFG_BITS){cfg.max_duration[CFG_BITS-1]}}, cfg.max_duration};
        in_range = ($signed(inside_reg) >= min_ext) && ($signed(inside_reg) <= max_ext);
    end

    assign md_req.start   = (state_reg == ST_LAUNCH);
    assign md_req.out_val = out_sel;
    assign md_req.mag     = mag_reg;
    assign md_req.divisor = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        eval_en    = 1'b0;
        grab       = 1'b0;
        fin_load   = 1'b0;
        count_next = count_reg;
        out_free   = !out_valid_reg || !out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                eval_en = 1'b1;
                if (!seg_reg)
                begin
                    state_next = ST_FIN;
                end
                else if (!cfg.duration_mode)
                begin
                    count_next = sat_add(count_reg, {1'b0, p_span} + {1'b0, p_inner});
                    state_next = ST_FIN;
                end
                else if (case1 || case2)
                begin
                    state_next = ST_LAUNCH;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (md_stat.done)
                begin
                    grab       = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                count_next = sat_add(count_reg, {1'b0, in_range});
                if (!case_sel_reg && case2_reg)
                begin
                    state_next = ST_LAUNCH;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    fin_load   = 1'b1;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        accept = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg  <= '0;
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                prev_pos_reg  <= position;
                prev_time_reg <= timestamp;
                have_prev_reg <= !end_of_data;
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= prev_pos_reg;
            b_reg    <= position;
            dt_reg   <= dt_new;
            seg_reg  <= !path_start && have_prev_reg;
            last_reg <= end_of_data;
        end
        if (eval_en)
        begin
            case2_reg    <= case2;
            case_sel_reg <= !case1;
            b_above_reg  <= (b_x > u_x);
            d_llo_reg    <= d_llo;
            d_hiu_reg    <= d_hiu;
            d_bu_reg     <= d_bu;
            d_lb_reg     <= d_lb;
            dist_reg     <= dist_x[DIST_W-1:0];
            mag_reg      <= dt_abs[MAG_W-1:0];
        end
        else if (state_reg == ST_CHECK)
        begin
            // Move on to the leaving case once the crossing case is done.
            case_sel_reg <= 1'b1;
        end
        if (grab)
        begin
            inside_reg <= inside_new;
        end
        if (fin_load)
        begin
            visit_total_reg <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign visit_total = visit_total_reg;

`ifndef NO_ASSERTIONS
    a_total_from_end_node: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN && last_reg))
        else $error("output word raised without an end node");

    a_unit_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !md_stat.busy)
        else $error("scaling unit busy while the sequencer waits for a node");

    a_unit_only_duration: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> cfg.duration_mode)
        else $error("scaling unit started in plain mode");
`endif

endmodule

// File: rtl/core/tivc_cfg.sv
// Configuration register file of the trajectory visit counter.
module tivc_cfg
    import tivc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_LOWER: cfg_reg.lower_bound   <= cfg_data[COORD_BITS-1:0];
                REG_UPPER: cfg_reg.upper_bound   <= cfg_data[COORD_BITS-1:0];
                REG_MIN:   cfg_reg.min_duration  <= cfg_data;
                REG_MAX:   cfg_reg.max_duration  <= cfg_data;
                REG_MODE:  cfg_reg.duration_mode <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/tivc_muldiv.sv
// Bit-serial unit that computes min(floor(out * mag / dist), 2^QBITS), zero when dist is zero.
module tivc_muldiv
    import tivc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  md_req_t  req,
    output md_stat_t stat
);

    md_state_t         state_reg, state_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [OUT_W-1:0]  mcand_reg, mcand_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              sat_reg, sat_next;

    logic [OUT_W:0]    psum;
    logic [DIST_W:0]   trial;
    logic [DIST_W:0]   diff;
    logic [DIST_W-1:0] head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        dist_reg  <= dist_next;
        mcand_reg <= mcand_next;
        step_reg  <= step_next;
        sat_reg   <= sat_next;
    end

    always_comb
    begin
        // The multiplier shifts out of the low end; the high half takes the partial sums.
        psum  = {1'b0, prod_reg[PROD_W-1:MAG_W]} + {1'b0, mcand_reg};
        // During division the low QBITS bits shift out the dividend and shift in the quotient.
        trial = {rem_reg, prod_reg[QBITS-1]};
        diff  = trial - {1'b0, dist_reg};
        head  = {{(DIST_W - HEAD_W){1'b0}}, prod_reg[PROD_W-1:QBITS]};

        state_next = state_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        dist_next  = dist_reg;
        mcand_next = mcand_reg;
        step_next  = step_reg;
        sat_next   = sat_reg;

        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next = req.out_val;
                    dist_next  = req.divisor;
                    sat_next   = 1'b0;
                    if (req.divisor == '0)
                    begin
                        prod_next  = '0;
                        state_next = MD_DONE;
                    end
                    else
                    begin
                        prod_next  = {{OUT_W{1'b0}}, req.mag};
                        step_next  = STEP_W'(MAG_W - 1);
                        state_next = MD_MUL;
                    end
                end
            end
            MD_MUL:
            begin
                if (prod_reg[0])
                begin
                    prod_next = {psum, prod_reg[MAG_W-1:1]};
                end
                else
                begin
                    prod_next = {1'b0, prod_reg[PROD_W-1:1]};
                end
                if (step_reg == '0)
                begin
                    state_next = MD_SAT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            MD_SAT:
            begin
                // A quotient of 2^QBITS or more shows as a high part not below the divisor.
                rem_next = head;
                if (head >= dist_reg)
                begin
                    sat_next   = 1'b1;
                    state_next = MD_DONE;
                end
                else
                begin
                    step_next  = STEP_W'(QBITS - 1);
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                if (!diff[DIST_W])
                begin
                    rem_next  = diff[DIST_W-1:0];
                    prod_next = {prod_reg[PROD_W-1:QBITS], prod_reg[QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[DIST_W-1:0];
                    prod_next = {prod_reg[PROD_W-1:QBITS], prod_reg[QBITS-2:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    state_next = MD_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    assign stat.busy = (state_reg != MD_IDLE);
    assign stat.done = (state_reg == MD_DONE);
    assign stat.quot = sat_reg ? {1'b1, {QBITS{1'b0}}} : {1'b0, prod_reg[QBITS-1:0]};

endmodule

// File: tb/visit_total_checker.sv
// Checker of the trajectory visit counter: predicts each total word and compares it on arrival.
module visit_total_checker
    import tivc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [IDX_BITS-1:0]          cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] position,
    input  logic signed [TIME_BITS-1:0]  timestamp,
    input  logic                         path_start,
    input  logic                         end_of_data,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [COUNT_BITS-1:0]        visit_total,
    output int                           mismatches,
    output int                           outstanding
);

    localparam logic [127:0] SCALE_CAP = 128'd1 << 40;

    // Shadow of the configuration registers.
    longint lower_q;
    longint upper_q;
    longint min_q;
    longint max_q;
    logic   dur_mode;

    // Shadow of the stored node and the running count.
    longint                  prev_x;
    longint                  prev_t;
    logic                    have_prev;
    logic [COUNT_BITS-1:0]   visit_tally;
    logic [COUNT_BITS-1:0]   expected_totals[$];
    logic [COUNT_BITS-1:0]   want;
    int                      hits;

    // The time inside is the segment time less the share of it spent outside,
    // truncated toward zero; the scaled share is capped at 2^40.
    function automatic logic duration_accepted(longint outside, longint span, longint dt);
        logic [127:0] scaled;
        longint       mag;
        longint       in_time;
        scaled = '0;
        if (span > 0) begin
            mag = (dt < 0) ? -dt : dt;
            scaled = (128'(outside) * 128'(mag)) / 128'(span);
            if (scaled > SCALE_CAP)
                scaled = SCALE_CAP;
        end
        in_time = (dt < 0) ? dt + longint'(scaled) : dt - longint'(scaled);
        return (in_time >= min_q) && (in_time <= max_q);
    endfunction

    function automatic int segment_visits(longint a, longint b, longint dt);
        longint lo;
        longint hi;
        longint beyond;
        int     n;
        n = 0;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (!dur_mode) begin
            if (lo <= lower_q && hi >= lower_q)
                n++;
            if (lo > lower_q && lo <= upper_q)
                n++;
        end
        else begin
            // Crosses the whole interval in either direction.
            if ((a <= lower_q && b > upper_q) || (a >= upper_q && b < lower_q)) begin
                beyond = (hi > upper_q) ? hi - upper_q : 0;
                if (duration_accepted(lower_q - lo + beyond, hi - lo, dt))
                    n++;
            end
            // Starts inside and leaves through either edge.
            if (a > lower_q && a <= upper_q && (b > upper_q || b < lower_q)) begin
                beyond = (b > upper_q) ? b - upper_q : lower_q - b;
                if (duration_accepted(beyond, hi - lo, dt))
                    n++;
            end
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_q     = 0;
            upper_q     = 0;
            min_q       = 0;
            max_q       = 0;
            dur_mode    = 1'b0;
            prev_x      = 0;
            prev_t      = 0;
            have_prev   = 1'b0;
            visit_tally = '0;
            expected_totals.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Compare before taking a new node: a word leaving now is always older.
            if (out_valid && !out_stall)
            begin
                if (expected_totals.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("visit_total %0d arrived with none expected at %0t",
                                 visit_total, $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_totals.pop_front();
                    if (visit_total !== want)
                    begin
                        if (mismatches < 10)
                            $display("visit_total mismatch at %0t: expected %0d, got %0d",
                                     $time, want, visit_total);
                        mismatches++;
                    end
                end
            end

            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_LOWER: lower_q  = longint'(signed'(cfg_data));
                    REG_UPPER: upper_q  = longint'(signed'(cfg_data));
                    REG_MIN:   min_q    = longint'(signed'(cfg_data));
                    REG_MAX:   max_q    = longint'(signed'(cfg_data));
                    REG_MODE:  dur_mode = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                hits = 0;
                if (!path_start && have_prev)
                    hits = segment_visits(prev_x, longint'(position),
                                          longint'(timestamp) - prev_t);
                repeat (hits)
                    if (visit_tally != '1)
                        visit_tally = visit_tally + 1'b1;
                prev_x    = longint'(position);
                prev_t    = longint'(timestamp);
                have_prev = 1'b1;
                if (end_of_data)
                begin
                    expected_totals.push_back(visit_tally);
                    visit_tally = '0;
                    have_prev   = 1'b0;
                end
            end

            outstanding = expected_totals.size();
        end
    end

endmodule

// File: tb/tb.sv
// Testbench top of the trajectory visit counter: clock, reset, node stimulus and verdict.
module tb;
    import tivc_pkg::*;

    localparam int DRAIN_CYCLES = 200;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 185;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write_en;
    logic [IDX_BITS-1:0]          cfg_index;
    logic [CFG_BITS-1:0]          cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] position;
    logic signed [TIME_BITS-1:0]  timestamp;
    logic                         path_start;
    logic                         end_of_data;
    logic                         out_valid;
    logic                         out_stall;
    logic [COUNT_BITS-1:0]        visit_total;
    int                           mismatches;
    int                           outstanding;

    // Interval currently programmed, used to aim positions at its edges.
    longint cur_lower;
    longint cur_upper;
    longint node_clock;
    logic   sender_gaps;
    logic   steady_tail;

    trajectory_interval_visit_counter u_dut (.*);

    visit_total_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    // Receiver side: stall bursts mixed with long stretches of free flow.
    initial
    begin : receiver
        int pick;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            pick = $urandom_range(0, 9);
            if (!steady_tail && pick < 2)
                repeat ($urandom_range(50, 300)) @(posedge clk);
            else if (!steady_tail && pick < 5)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_word(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] d);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= d;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [31:0] lo, input logic [31:0] hi,
                                  input logic [31:0] dmin, input logic [31:0] dmax,
                                  input logic mode);
        cur_lower = longint'(signed'(lo));
        cur_upper = longint'(signed'(hi));
        write_word(REG_LOWER, lo);
        write_word(REG_UPPER, hi);
        write_word(REG_MIN, dmin);
        write_word(REG_MAX, dmax);
        write_word(REG_MODE, CFG_BITS'(mode));
        // A write past the last register must leave everything unchanged.
        write_word(IDX_BITS'(REG_MODE + 1 + $urandom_range(0, 2)), $urandom);
        cfg_write_en <= 1'b0;
    endtask

    // Leaves in_valid high on return, so back-to-back words go without a gap in in_valid.
    task automatic send_node(input logic [31:0] x, input logic [31:0] t,
                             input logic start, input logic last);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        position    <= x;
        timestamp   <= t;
        path_start  <= start;
        end_of_data <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The checker may not yet count a new end node when this task starts, hence the first wait.
    task automatic wait_idle();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_position();
        int     pick;
        longint base;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        base = (pick % 2 == 1) ? cur_lower : cur_upper;
        return 32'(base + longint'($urandom_range(0, 600)) - 300);
    endfunction

    function automatic logic [31:0] pick_timestamp();
        int                 pick;
        logic signed [31:0] raw;
        pick = $urandom_range(0, 19);
        raw = $urandom;
        if (pick == 0)
            node_clock = longint'(raw);
        else if (pick < 3)
            node_clock = node_clock - $urandom_range(0, 500);
        else
            node_clock = node_clock + $urandom_range(0, 500);
        return 32'(node_clock);
    endfunction

    initial
    begin : stimulus
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] dmin;
        logic [31:0] dmax;
        logic        mode;
        logic        last;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        position     <= '0;
        timestamp    <= '0;
        path_start   <= 1'b0;
        end_of_data  <= 1'b0;
        sender_gaps  = 1'b1;
        steady_tail  = 1'b0;
        node_clock   = 0;
        cur_lower    = 0;
        cur_upper    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain counting: extreme positions and timestamps, a node landing on the lower
        // edge, a lone end node and a node that both starts a path and ends the data.
        apply_settings(-32'sd100, 32'sd100, 32'sd0, 32'sd0, 1'b0);
        send_node(32'h8000_0000, 32'd0, 1'b1, 1'b0);
        send_node(32'h7FFF_FFFF, 32'd10, 1'b0, 1'b0);
        send_node(32'sd50, 32'd20, 1'b0, 1'b0);
        send_node(-32'sd100, 32'h8000_0000, 1'b0, 1'b0);
        send_node(32'sd100, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_node(32'sd200, 32'd5, 1'b0, 1'b1);
        send_node(32'sd0, 32'd0, 1'b0, 1'b1);
        send_node(32'sd5, 32'd1, 1'b1, 1'b1);
        in_valid <= 1'b0;
        wait_idle();

        // Duration mode: crossing both ways, leaving above and below, time running
        // backward, and one segment that both crosses and leaves.
        apply_settings(-32'sd100, 32'sd100, 32'sd10, 32'sd60, 1'b1);
        send_node(-32'sd200, 32'd0, 1'b1, 1'b0);
        send_node(32'sd200, 32'd100, 1'b0, 1'b0);
        send_node(32'sd50, 32'd130, 1'b0, 1'b0);
        send_node(32'sd300, 32'd170, 1'b0, 1'b0);
        send_node(32'sd0, 32'd200, 1'b0, 1'b0);
        send_node(-32'sd300, 32'd230, 1'b0, 1'b0);
        send_node(32'sd300, 32'd200, 1'b0, 1'b0);
        send_node(32'sd100, 32'd260, 1'b0, 1'b0);
        send_node(-32'sd150, 32'd300, 1'b0, 1'b1);
        in_valid <= 1'b0;
        wait_idle();

        // Inverted interval with a zero-length crossing, widest duration window.
        apply_settings(32'sd10, -32'sd10, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_node(32'sd0, 32'd0, 1'b1, 1'b0);
        send_node(32'sd0, 32'd7, 1'b0, 1'b0);
        send_node(32'sd20, 32'd9, 1'b0, 1'b0);
        send_node(-32'sd20, 32'd12, 1'b0, 1'b1);
        in_valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            lo   = $urandom_range(0, 4000) - 2000;
            hi   = lo + $urandom_range(0, 2000);
            dmin = $urandom_range(0, 200);
            dmax = dmin + $urandom_range(0, 400);
            mode = p[0];
            case (p)
                2:
                begin
                    lo   = 32'h8000_0000;
                    hi   = 32'h7FFF_FFFF;
                    dmin = 32'h8000_0000;
                    dmax = 32'h7FFF_FFFF;
                    mode = 1'b1;
                end
                3:
                begin
                    // Widest inverted interval drives the scaled share into its cap.
                    lo   = 32'h7FFF_FFFF;
                    hi   = 32'h8000_0000;
                    dmin = 32'h8000_0000;
                    mode = 1'b1;
                end
                4:
                begin
                    lo   = 32'h7FFF_FFFF;
                    hi   = 32'h8000_0000;
                    mode = 1'b0;
                end
                5: hi = lo;
                6: hi = lo - $urandom_range(1, 500);
                7: dmax = dmin - $urandom_range(1, 100);
                default: ;
            endcase
            apply_settings(lo, hi, dmin, dmax, mode);

            if (p == PHASES - 1)
            begin
                steady_tail = 1'b1;
                sender_gaps = 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (!steady_tail && k % 40 == 0)
                    sender_gaps = ($urandom_range(0, 2) != 0);
                last = (k == PHASE_ITEMS - 1) || ($urandom_range(0, 11) == 0);
                send_node(pick_position(), pick_timestamp(),
                          $urandom_range(0, 11) == 0, last);
            end
            in_valid <= 1'b0;
            wait_idle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
